@@ src/pmp_pkg.sv @@
// ----------------------------------------------------------------------------
// pmp_pkg
// Shared types and constants of the protobuf message parser: position width,
// varint limits, field and wire-type codes, and the parser phase encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package pmp_pkg;

    localparam int POS_BITS = 16;
    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

    localparam int VARINT_BITS = 64;
    localparam int SHIFT_BITS = 6;
    localparam int COUNT_BITS = 4;
    localparam logic [SHIFT_BITS-1:0] SHIFT_STEP = 6'd7;
    localparam logic [COUNT_BITS-1:0] VARINT_LAST_COUNT = 4'd9;

    localparam logic [31:0] FIELD_KEY = 32'd1;
    localparam logic [31:0] FIELD_COUNTER = 32'd2;
    localparam logic [31:0] FIELD_PREV_LENGTH = 32'd3;
    localparam logic [31:0] FIELD_PAYLOAD = 32'd4;

    localparam logic [2:0] WIRE_VARINT = 3'd0;
    localparam logic [2:0] WIRE_LEN_DELIM = 3'd2;

    localparam logic [1:0] IDX_KEY = 2'd0;
    localparam logic [1:0] IDX_COUNTER = 2'd1;
    localparam logic [1:0] IDX_PREV_LENGTH = 2'd2;
    localparam logic [1:0] IDX_PAYLOAD = 2'd3;

    typedef enum logic [4:0] {
        PH_TAG   = 5'b00001,
        PH_LEN   = 5'b00010,
        PH_VALUE = 5'b00100,
        PH_SKIP  = 5'b01000,
        PH_ERROR = 5'b10000
    } phase_t;

endpackage

`default_nettype wire

@@ src/protobuf_message_parser_core.sv @@
// ----------------------------------------------------------------------------
// protobuf_message_parser_core
// Streaming parser for a four-field protobuf message, one byte per item.
// ----------------------------------------------------------------------------
// The block takes one byte item in every cycle unless input is stalled,
// and updates its parser state in that same cycle. The single result item
// appears in the output register in the cycle after the byte marked last
// is accepted, and the next message may start in the cycle right after
// that byte. Input is stalled only while a finished result sits in the
// output register and the receiver stalls it. Byte throughput is set by
// the varint accumulate and compare path.
// ----------------------------------------------------------------------------
`default_nettype none

module protobuf_message_parser_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             status,
    output logic [31:0]      counter_value,
    output logic [31:0]      previous_chain_length,
    output logic [15:0]      key_offset,
    output logic [15:0]      key_length,
    output logic [15:0]      payload_offset,
    output logic [15:0]      payload_length
);

    import pmp_pkg::*;

    phase_t                  phase_reg, phase_next;
    logic [VARINT_BITS-1:0]  acc_reg, acc_next;
    logic [SHIFT_BITS-1:0]   shift_reg, shift_next;
    logic [COUNT_BITS-1:0]   count_reg, count_next;
    logic [1:0]              field_reg, field_next;
    logic [POS_BITS-1:0]     pos_reg, pos_next;
    logic [POS_BITS-1:0]     skip_reg, skip_next;
    logic [3:0]              seen_reg, seen_next;
    logic [31:0]             held_counter_reg, held_counter_next;
    logic [31:0]             held_prev_reg, held_prev_next;
    logic [POS_BITS-1:0]     held_key_off_reg, held_key_off_next;
    logic [POS_BITS-1:0]     held_key_len_reg, held_key_len_next;
    logic [POS_BITS-1:0]     held_pay_off_reg, held_pay_off_next;
    logic [POS_BITS-1:0]     held_pay_len_reg, held_pay_len_next;

    logic                    out_valid_reg;
    logic                    status_reg;
    logic [31:0]             counter_reg;
    logic [31:0]             prev_length_reg;
    logic [15:0]             key_offset_reg;
    logic [15:0]             key_length_reg;
    logic [15:0]             payload_offset_reg;
    logic [15:0]             payload_length_reg;

    logic                    accept;
    logic [VARINT_BITS-1:0]  acc_word;
    logic [31:0]             tag_field;
    logic [2:0]              tag_wire;
    logic                    tag_ok;
    logic [1:0]              tag_index;
    logic [POS_BITS-1:0]     pos_inc;
    logic [POS_BITS-1:0]     room;
    logic [POS_BITS-1:0]     len_low;
    logic                    len_high;
    logic                    good;
    logic [31:0]             key_off_ext;
    logic [31:0]             key_len_ext;
    logic [31:0]             pay_off_ext;
    logic [31:0]             pay_len_ext;

    assign in_stall = out_valid_reg && out_stall;
    assign accept = in_valid && !in_stall;

    assign acc_word = acc_reg | (VARINT_BITS'(data_byte[6:0]) << shift_reg);
    assign tag_field = acc_word[34:3];
    assign tag_wire = acc_word[2:0];
    assign tag_ok = ((tag_field == FIELD_KEY || tag_field == FIELD_PAYLOAD)
                     && tag_wire == WIRE_LEN_DELIM)
                 || ((tag_field == FIELD_COUNTER || tag_field == FIELD_PREV_LENGTH)
                     && tag_wire == WIRE_VARINT);
    assign tag_index = tag_field[1:0] - 2'd1;
    assign pos_inc = pos_reg + 1'b1;
    assign room = POS_MAX - pos_inc;
    assign len_low = acc_word[POS_BITS-1:0];
    assign len_high = |acc_word[VARINT_BITS-1:POS_BITS];

    always_comb
    begin
        phase_next = phase_reg;
        acc_next = acc_reg;
        shift_next = shift_reg;
        count_next = count_reg;
        field_next = field_reg;
        pos_next = pos_reg;
        skip_next = skip_reg;
        seen_next = seen_reg;
        held_counter_next = held_counter_reg;
        held_prev_next = held_prev_reg;
        held_key_off_next = held_key_off_reg;
        held_key_len_next = held_key_len_reg;
        held_pay_off_next = held_pay_off_reg;
        held_pay_len_next = held_pay_len_reg;

        if (phase_reg != PH_ERROR)
        begin
            if (pos_reg == POS_MAX)
            begin
                phase_next = PH_ERROR;
            end
            else
            begin
                pos_next = pos_inc;
                if (phase_reg == PH_SKIP)
                begin
                    skip_next = skip_reg - 1'b1;
                    if (skip_reg == POS_BITS'(1))
                    begin
                        phase_next = PH_TAG;
                    end
                end
                else if (data_byte[7])
                begin
                    acc_next = acc_word;
                    count_next = count_reg + 1'b1;
                    shift_next = shift_reg + SHIFT_STEP;
                    if (count_reg == VARINT_LAST_COUNT)
                    begin
                        phase_next = PH_ERROR;
                    end
                end
                else
                begin
                    acc_next = '0;
                    shift_next = '0;
                    count_next = '0;
                    case (phase_reg)
                        PH_TAG:
                        begin
                            if (!tag_ok || seen_reg[tag_index])
                            begin
                                phase_next = PH_ERROR;
                            end
                            else
                            begin
                                field_next = tag_index;
                                phase_next = (tag_wire == WIRE_LEN_DELIM) ? PH_LEN : PH_VALUE;
                            end
                        end
                        PH_LEN:
                        begin
                            if (len_high || len_low > room)
                            begin
                                phase_next = PH_ERROR;
                            end
                            else
                            begin
                                if (field_reg == IDX_KEY)
                                begin
                                    held_key_off_next = pos_inc;
                                    held_key_len_next = len_low;
                                end
                                else
                                begin
                                    held_pay_off_next = pos_inc;
                                    held_pay_len_next = len_low;
                                end
                                seen_next[field_reg] = 1'b1;
                                if (len_low == '0)
                                begin
                                    phase_next = PH_TAG;
                                end
                                else
                                begin
                                    skip_next = len_low;
                                    phase_next = PH_SKIP;
                                end
                            end
                        end
                        PH_VALUE:
                        begin
                            if (|acc_word[VARINT_BITS-1:32])
                            begin
                                phase_next = PH_ERROR;
                            end
                            else
                            begin
                                if (field_reg == IDX_COUNTER)
                                begin
                                    held_counter_next = acc_word[31:0];
                                end
                                else
                                begin
                                    held_prev_next = acc_word[31:0];
                                end
                                seen_next[field_reg] = 1'b1;
                                phase_next = PH_TAG;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_ERROR;
                        end
                    endcase
                end
            end
        end
    end

    assign good = (phase_next == PH_TAG) && (count_next == '0) && (seen_next == 4'hF);

    assign key_off_ext = 32'(held_key_off_next);
    assign key_len_ext = 32'(held_key_len_next);
    assign pay_off_ext = 32'(held_pay_off_next);
    assign pay_len_ext = 32'(held_pay_len_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TAG;
            acc_reg <= '0;
            shift_reg <= '0;
            count_reg <= '0;
            field_reg <= '0;
            pos_reg <= '0;
            skip_reg <= '0;
            seen_reg <= '0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                phase_reg <= PH_TAG;
                acc_reg <= '0;
                shift_reg <= '0;
                count_reg <= '0;
                field_reg <= '0;
                pos_reg <= '0;
                skip_reg <= '0;
                seen_reg <= '0;
            end
            else
            begin
                phase_reg <= phase_next;
                acc_reg <= acc_next;
                shift_reg <= shift_next;
                count_reg <= count_next;
                field_reg <= field_next;
                pos_reg <= pos_next;
                skip_reg <= skip_next;
                seen_reg <= seen_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            held_counter_reg <= held_counter_next;
            held_prev_reg <= held_prev_next;
            held_key_off_reg <= held_key_off_next;
            held_key_len_reg <= held_key_len_next;
            held_pay_off_reg <= held_pay_off_next;
            held_pay_len_reg <= held_pay_len_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept && last_byte)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && last_byte)
        begin
            status_reg <= !good;
            counter_reg <= good ? held_counter_next : '0;
            prev_length_reg <= good ? held_prev_next : '0;
            key_offset_reg <= good ? key_off_ext[15:0] : '0;
            key_length_reg <= good ? key_len_ext[15:0] : '0;
            payload_offset_reg <= good ? pay_off_ext[15:0] : '0;
            payload_length_reg <= good ? pay_len_ext[15:0] : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign status = status_reg;
    assign counter_value = counter_reg;
    assign previous_chain_length = prev_length_reg;
    assign key_offset = key_offset_reg;
    assign key_length = key_length_reg;
    assign payload_offset = payload_offset_reg;
    assign payload_length = payload_length_reg;

    // A rejected message reports no field values.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> counter_value == '0 && previous_chain_length == '0
            && key_offset == '0 && key_length == '0
            && payload_offset == '0 && payload_length == '0)
        else $error("rejected message carries nonzero fields");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_byte |=> out_valid)
        else $error("last byte accepted without a result");

    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_SKIP |-> skip_reg != '0)
        else $error("skip phase with nothing left to skip");

    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PH_ERROR |-> count_reg <= VARINT_LAST_COUNT
            && 7'(shift_reg) == 7'(count_reg) * 7'd7)
        else $error("varint shift out of step with byte count");

endmodule

`default_nettype wire

@@ tb/protobuf_message_parser_core_tb.sv @@
// ----------------------------------------------------------------------------
// protobuf_message_parser_core_tb
// Streams serialized messages, one byte per item, into the four-field parser.
// A scoreboard object follows the byte stream with its own parser and queues
// the result that each marked last byte should produce. Results are checked
// field by field in arrival order. Directed messages come first: extreme
// values, ten-byte varints and every kind of malformed message that a short
// message can show. Random messages follow, most of them well formed, the
// rest broken in one random way. Both sides idle and stall at random, and
// the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module protobuf_message_parser_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import pmp_pkg::*;

    localparam int VARINT_MAX_BYTES = 10;
    localparam int RANDOM_BYTES = 1500;
    localparam int HOLD_AT = 40;
    localparam int HOLD_CYCLES = 300;
    localparam int unsigned CYCLE_LIMIT = 1000000;

    typedef enum int {
        FLAW_NONE,
        FLAW_TRUNCATE,
        FLAW_DUPLICATE,
        FLAW_MISSING,
        FLAW_UNKNOWN_FIELD,
        FLAW_WIRE_TYPE,
        FLAW_OVERSIZED,
        FLAW_LENGTH_LONG,
        FLAW_OVERLONG,
        FLAW_NOISE
    } flaw_t;

    typedef struct packed {
        logic        status;
        logic [31:0] counter;
        logic [31:0] prev_len;
        logic [15:0] key_off;
        logic [15:0] key_len;
        logic [15:0] pay_off;
        logic [15:0] pay_len;
    } parse_result_t;

    class parse_scoreboard;
        phase_t              ph;
        logic [63:0]         acc;
        int                  vshift;
        int                  vcount;
        logic [31:0]         cur_field;
        logic [POS_BITS-1:0] pos;
        logic [POS_BITS-1:0] skip;
        logic [3:0]          seen;
        logic [31:0]         held_counter;
        logic [31:0]         held_prev_len;
        logic [15:0]         held_key_off;
        logic [15:0]         held_key_len;
        logic [15:0]         held_pay_off;
        logic [15:0]         held_pay_len;

        parse_result_t expected_q[$];
        int mismatches;
        int results_seen;
        int bytes_seen;
        int ok_msgs;
        int bad_msgs;

        function new();
            clear_state();
        endfunction

        function void clear_state();
            ph = PH_TAG;
            acc = '0;
            vshift = 0;
            vcount = 0;
            cur_field = '0;
            pos = '0;
            skip = '0;
            seen = '0;
            held_counter = '0;
            held_prev_len = '0;
            held_key_off = '0;
            held_key_len = '0;
            held_pay_off = '0;
            held_pay_len = '0;
        endfunction

        function void take_tag(logic [63:0] tag);
            logic [31:0] fn;
            logic [2:0]  wt;
            bit          ok;
            fn = tag[34:3];
            wt = tag[2:0];
            ok = ((fn == FIELD_KEY || fn == FIELD_PAYLOAD) && wt == WIRE_LEN_DELIM) ||
                 ((fn == FIELD_COUNTER || fn == FIELD_PREV_LENGTH) && wt == WIRE_VARINT);
            if (!ok || seen[fn[1:0] - 2'd1])
            begin
                ph = PH_ERROR;
                return;
            end
            cur_field = fn;
            ph = (wt == WIRE_LEN_DELIM) ? PH_LEN : PH_VALUE;
        endfunction

        function void take_length(logic [63:0] len);
            if (len > 64'(POS_MAX - pos))
            begin
                ph = PH_ERROR;
                return;
            end
            if (cur_field == FIELD_KEY)
            begin
                held_key_off = 16'(pos);
                held_key_len = 16'(len);
            end
            else
            begin
                held_pay_off = 16'(pos);
                held_pay_len = 16'(len);
            end
            seen[cur_field[1:0] - 2'd1] = 1'b1;
            if (len == 64'd0)
                ph = PH_TAG;
            else
            begin
                skip = POS_BITS'(len);
                ph = PH_SKIP;
            end
        endfunction

        function void take_value(logic [63:0] v);
            if (v > 64'hFFFF_FFFF)
            begin
                ph = PH_ERROR;
                return;
            end
            if (cur_field == FIELD_COUNTER)
                held_counter = v[31:0];
            else
                held_prev_len = v[31:0];
            seen[cur_field[1:0] - 2'd1] = 1'b1;
            ph = PH_TAG;
        endfunction

        function void consume(logic [7:0] b);
            logic [63:0] v;
            if (ph == PH_ERROR)
                return;
            if (pos >= POS_MAX)
            begin
                ph = PH_ERROR;
                return;
            end
            pos++;
            if (ph == PH_SKIP)
            begin
                skip--;
                if (skip == '0)
                    ph = PH_TAG;
                return;
            end
            acc |= 64'(b[6:0]) << (vshift & 63);
            if (b[7])
            begin
                vcount++;
                vshift += 7;
                if (vcount >= VARINT_MAX_BYTES)
                    ph = PH_ERROR;
                return;
            end
            v = acc;
            acc = '0;
            vshift = 0;
            vcount = 0;
            case (ph)
                PH_TAG: take_tag(v);
                PH_LEN: take_length(v);
                default: take_value(v);
            endcase
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            parse_result_t r;
            bytes_seen++;
            consume(b);
            if (!last)
                return;
            r = '0;
            if (ph == PH_TAG && vcount == 0 && seen == 4'hF)
            begin
                r.counter = held_counter;
                r.prev_len = held_prev_len;
                r.key_off = held_key_off;
                r.key_len = held_key_len;
                r.pay_off = held_pay_off;
                r.pay_len = held_pay_len;
                ok_msgs++;
            end
            else
            begin
                r.status = 1'b1;
                bad_msgs++;
            end
            expected_q.push_back(r);
            clear_state();
        endfunction

        function void check_result(parse_result_t got);
            parse_result_t want;
            logic [31:0]   w[7];
            logic [31:0]   g[7];
            string         names[7];
            results_seen++;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result with no message pending, status %0d", got.status);
                return;
            end
            want = expected_q.pop_front();
            names = '{"status", "counter_value", "previous_chain_length", "key_offset",
                      "key_length", "payload_offset", "payload_length"};
            w = '{32'(want.status), want.counter, want.prev_len, 32'(want.key_off),
                  32'(want.key_len), 32'(want.pay_off), 32'(want.pay_len)};
            g = '{32'(got.status), got.counter, got.prev_len, 32'(got.key_off),
                  32'(got.key_len), 32'(got.pay_off), 32'(got.pay_len)};
            for (int i = 0; i < 7; i++)
            begin
                if (w[i] !== g[i])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: result %0d %s expected 0x%0h got 0x%0h",
                                 results_seen, names[i], w[i], g[i]);
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        out_valid;
    logic        out_stall;
    logic        status;
    logic [31:0] counter_value;
    logic [31:0] previous_chain_length;
    logic [15:0] key_offset;
    logic [15:0] key_length;
    logic [15:0] payload_offset;
    logic [15:0] payload_length;

    parse_scoreboard sb;
    logic [7:0]      msg[$];
    bit              calm;
    int unsigned     cycle_count;

    protobuf_message_parser_core dut (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .in_valid              (in_valid),
        .in_stall              (in_stall),
        .data_byte             (data_byte),
        .last_byte             (last_byte),
        .out_valid             (out_valid),
        .out_stall             (out_stall),
        .status                (status),
        .counter_value         (counter_value),
        .previous_chain_length (previous_chain_length),
        .key_offset            (key_offset),
        .key_length            (key_length),
        .payload_offset        (payload_offset),
        .payload_length        (payload_length)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("protobuf_message_parser_core_tb: FAIL");
            $finish;
        end
    end

    function automatic int rand_pad();
        return ($urandom_range(7) == 0) ? int'($urandom_range(1, 9)) : 0;
    endfunction

    // A negative pad gives an eleven-byte encoding, one byte too many.
    function automatic void put_varint(logic [63:0] v, int pad);
        int n;
        n = 1;
        while (n < VARINT_MAX_BYTES && (v >> (7 * n)) != 64'd0)
            n++;
        if (pad < 0)
            n = VARINT_MAX_BYTES + 1;
        else if (n + pad > VARINT_MAX_BYTES)
            n = VARINT_MAX_BYTES;
        else
            n = n + pad;
        for (int i = 0; i < n; i++)
            msg.push_back({i < n - 1, 7'(v >> (7 * i))});
    endfunction

    function automatic void put_plain(int f, logic [63:0] val, int pad);
        bit lendelim;
        lendelim = (f == FIELD_KEY || f == FIELD_PAYLOAD);
        put_varint({61'(f), lendelim ? WIRE_LEN_DELIM : WIRE_VARINT}, pad);
        put_varint(val, pad);
        if (lendelim)
            repeat (int'(val)) msg.push_back(8'($urandom));
    endfunction

    function automatic void put_rest(int omit);
        for (int f = 1; f <= 4; f++)
        begin
            if (f != omit)
                put_plain(f, (f == FIELD_KEY || f == FIELD_PAYLOAD) ?
                          64'($urandom_range(0, 6)) : 64'($urandom), 0);
        end
    endfunction

    function automatic void put_field(int f, flaw_t flaw);
        logic [60:0] fnum;
        logic [2:0]  wt;
        logic [63:0] val;
        bit          lendelim;
        bit          long_tag;
        lendelim = (f == FIELD_KEY || f == FIELD_PAYLOAD);
        fnum = 61'(f);
        wt = lendelim ? WIRE_LEN_DELIM : WIRE_VARINT;
        long_tag = (flaw == FLAW_OVERLONG) && ($urandom_range(1) == 1);
        if ($urandom_range(9) == 0)
            fnum[60:32] = 29'($urandom);
        if (flaw == FLAW_UNKNOWN_FIELD)
        begin
            case ($urandom_range(2))
                0: fnum = '0;
                1: fnum = 61'($urandom_range(5, 40));
                default: fnum = {29'($urandom), $urandom | 32'h8};
            endcase
            wt = 3'($urandom);
        end
        if (flaw == FLAW_WIRE_TYPE)
            wt = wt ^ 3'($urandom_range(1, 7));
        put_varint({fnum, wt}, long_tag ? -1 : rand_pad());
        if (lendelim)
        begin
            val = 64'($urandom_range(0, (f == FIELD_KEY) ? 8 : 24));
            if (flaw == FLAW_LENGTH_LONG)
                val = ($urandom_range(1) == 1) ? ({$urandom, $urandom} | 64'h1_0000) :
                      64'(65536 + $urandom_range(0, 3) - (msg.size() + 3));
        end
        else
        begin
            case ($urandom_range(15))
                0: val = 64'd0;
                1: val = 64'hFFFF_FFFF;
                default: val = 64'($urandom >> $urandom_range(0, 31));
            endcase
            if (flaw == FLAW_OVERSIZED)
                val = ({$urandom, $urandom} >> $urandom_range(0, 31)) | 64'h1_0000_0000;
        end
        put_varint(val, (flaw == FLAW_OVERLONG && !long_tag) ? -1 : rand_pad());
        if (lendelim && flaw != FLAW_LENGTH_LONG)
            repeat (int'(val)) msg.push_back(8'($urandom));
    endfunction

    function automatic void build_message(flaw_t flaw);
        int order[4];
        int target;
        int tmp;
        int j;
        int cut;
        msg.delete();
        if (flaw == FLAW_NOISE)
        begin
            repeat ($urandom_range(1, 12)) msg.push_back(8'($urandom));
            return;
        end
        for (int i = 0; i < 4; i++)
            order[i] = i + 1;
        for (int i = 3; i > 0; i--)
        begin
            j = $urandom_range(i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        target = $urandom_range(1, 4);
        if (flaw == FLAW_OVERSIZED)
            target = $urandom_range(2, 3);
        if (flaw == FLAW_LENGTH_LONG)
            target = ($urandom_range(1) == 1) ? int'(FIELD_PAYLOAD) : int'(FIELD_KEY);
        for (int i = 0; i < 4; i++)
        begin
            if (!(flaw == FLAW_MISSING && order[i] == target))
                put_field(order[i], (order[i] == target) ? flaw : FLAW_NONE);
        end
        if (flaw == FLAW_DUPLICATE)
            put_field(target, FLAW_NONE);
        if (flaw == FLAW_TRUNCATE && msg.size() > 1)
        begin
            cut = $urandom_range(1, msg.size() - 1);
            while (msg.size() > cut)
                void'(msg.pop_back());
        end
    endfunction

    function automatic flaw_t pick_flaw();
        if ($urandom_range(99) < 65)
            return FLAW_NONE;
        return flaw_t'($urandom_range(1, int'(FLAW_NOISE)));
    endfunction

    task automatic send_byte(logic [7:0] b, logic last);
        while (!calm && $urandom_range(99) < 6)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        last_byte <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_byte(b, last);
    endtask

    task automatic send_message();
        for (int i = 0; i < msg.size(); i++)
            send_byte(msg[i], i == msg.size() - 1);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int hold_left;
        bit hold_done;
        parse_result_t got;
        hold_left = 0;
        hold_done = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                got.status = status;
                got.counter = counter_value;
                got.prev_len = previous_chain_length;
                got.key_off = key_offset;
                got.key_len = key_length;
                got.pay_off = payload_offset;
                got.pay_len = payload_length;
                sb.check_result(got);
            end
            if (hold_left > 0)
                hold_left--;
            else if (!hold_done && sb.results_seen >= HOLD_AT)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            out_stall <= (hold_left > 0) || (!calm && $urandom_range(99) < 6);
        end
    end

    initial
    begin
        int n;
        int random_bytes;
        sb = new();
        calm = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        data_byte = '0;
        last_byte = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        msg.delete();
        put_plain(FIELD_KEY, 0, 0);
        put_plain(FIELD_COUNTER, 0, 0);
        put_plain(FIELD_PREV_LENGTH, 0, 0);
        put_plain(FIELD_PAYLOAD, 0, 0);
        send_message();

        msg.delete();
        put_plain(FIELD_PAYLOAD, 24, 0);
        put_plain(FIELD_PREV_LENGTH, 64'hFFFF_FFFF, 0);
        put_plain(FIELD_KEY, 8, 0);
        put_plain(FIELD_COUNTER, 64'hFFFF_FFFF, 0);
        send_message();

        // Ten-byte encodings everywhere; the first tag also carries field
        // number bits above the low 32, which the parser drops.
        msg.delete();
        put_varint(64'hFFFF_FFF8_0000_0010, 0);
        put_varint(64'h1234_5678, 9);
        put_plain(FIELD_KEY, 3, 9);
        put_plain(FIELD_PREV_LENGTH, 7, 9);
        put_plain(FIELD_PAYLOAD, 1, 9);
        send_message();

        msg.delete();
        put_plain(FIELD_COUNTER, 5, -1);
        put_rest(FIELD_COUNTER);
        send_message();

        msg.delete();
        put_rest(FIELD_PREV_LENGTH);
        put_varint({61'(FIELD_PREV_LENGTH), WIRE_VARINT}, 0);
        put_varint(64'd9, -1);
        send_message();

        msg.delete();
        put_plain(FIELD_KEY, 2, 0);
        put_plain(FIELD_COUNTER, 64'h1_0000_0000, 0);
        put_rest(FIELD_COUNTER);
        send_message();

        msg.delete();
        put_plain(FIELD_PREV_LENGTH, 64'hFFFF_FFFF_FFFF_FFFF, 0);
        put_rest(FIELD_PREV_LENGTH);
        send_message();

        msg.delete();
        put_varint({61'd5, WIRE_VARINT}, 0);
        put_varint(64'd1, 0);
        put_rest(0);
        send_message();

        msg.delete();
        put_varint(64'd0, 0);
        put_rest(0);
        send_message();

        msg.delete();
        put_varint({61'(FIELD_KEY), WIRE_VARINT}, 0);
        put_varint(64'd3, 0);
        put_rest(FIELD_KEY);
        send_message();

        msg.delete();
        put_rest(FIELD_COUNTER);
        put_varint({61'(FIELD_COUNTER), WIRE_LEN_DELIM}, 0);
        put_varint(64'd1, 0);
        msg.push_back(8'h5A);
        send_message();

        msg.delete();
        put_rest(0);
        put_plain(FIELD_COUNTER, 77, 0);
        send_message();

        msg.delete();
        put_rest(FIELD_PAYLOAD);
        send_message();

        msg.delete();
        put_plain(FIELD_COUNTER, 1, 0);
        put_varint({61'(FIELD_PAYLOAD), WIRE_LEN_DELIM}, 0);
        put_varint(64'd65535, 0);
        repeat (3) msg.push_back(8'($urandom));
        send_message();

        msg.delete();
        put_rest(FIELD_KEY);
        put_varint({61'(FIELD_KEY), WIRE_LEN_DELIM}, 0);
        put_varint(64'd10, 0);
        repeat (3) msg.push_back(8'($urandom));
        send_message();

        msg.delete();
        put_rest(0);
        msg.push_back(8'h80);
        send_message();

        msg.delete();
        msg.push_back(8'h00);
        send_message();

        msg.delete();
        msg.push_back(8'hFF);
        send_message();

        wait_drained();

        n = 0;
        random_bytes = 0;
        while (random_bytes < RANDOM_BYTES)
        begin
            calm = (n >= 20 && n < 36);
            if (n == 40)
                wait_drained();
            build_message(pick_flaw());
            random_bytes += msg.size();
            send_message();
            n++;
        end
        calm = 1'b0;

        wait_drained();
        repeat (20) @(posedge clk);

        $display("Checked %0d results from %0d bytes: %0d well formed, %0d rejected.",
                 sb.results_seen, sb.bytes_seen, sb.ok_msgs, sb.bad_msgs);
        $display("Covered every short malformed kind, ten-byte varints and a long receiver hold.");
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("protobuf_message_parser_core_tb: PASS");
        else
            $display("protobuf_message_parser_core_tb: FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
src/pmp_pkg.sv
src/protobuf_message_parser_core.sv
tb/protobuf_message_parser_core_tb.sv
